// ----- hw/rtl/tbrs_pkg.sv -----
// Package for the traction boost and ramp shaper: widths, register indexes,
// reset values and the structs shared by the channel interfaces and modules.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package tbrs_pkg;

  // Field widths.
  localparam int DUTY_W     = 11;
  localparam int STEP_W     = 10;
  localparam int DIST_W     = 16;
  localparam int TIME_W     = 32;
  localparam int DUR_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STEP         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECEL_STEP         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMERGENCY_DISTANCE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_MIN_DISTANCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_ENABLE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_DUTY         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_DURATION_MS  = 3'd6;

  // Register reset values.
  localparam logic [STEP_W-1:0] RST_ACCEL_STEP         = 10'd10;
  localparam logic [STEP_W-1:0] RST_DECEL_STEP         = 10'd20;
  localparam logic [DIST_W-1:0] RST_EMERGENCY_DISTANCE = 16'd320;
  localparam logic [DIST_W-1:0] RST_BOOST_MIN_DISTANCE = 16'd480;
  localparam logic              RST_BOOST_ENABLE       = 1'b1;
  localparam logic [STEP_W-1:0] RST_BOOST_DUTY         = 10'd800;
  localparam logic [DUR_W-1:0]  RST_BOOST_DURATION_MS  = 16'd200;

  // Current register settings.
  typedef struct packed {
    logic [STEP_W-1:0] accel_step;
    logic [STEP_W-1:0] decel_step;
    logic [DIST_W-1:0] emergency_distance;
    logic [DIST_W-1:0] boost_min_distance;
    logic              boost_enable;
    logic [STEP_W-1:0] boost_duty;
    logic [DUR_W-1:0]  boost_duration_ms;
  } cfg_t;

  // One control cycle as it arrives.
  typedef struct packed {
    logic signed [DUTY_W-1:0] target_traction;
    logic                     front_valid;
    logic [DIST_W-1:0]        front_distance;
    logic [TIME_W-1:0]        now_ms;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic signed [DUTY_W-1:0] applied_traction;
    logic                     boosting;
  } out_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tbrs_if.sv -----
// Valid/ready channel interfaces for the shaper's input and result streams.
// Depends on tbrs_pkg for the payload structs.
`timescale 1ns / 1ps
`default_nettype none

interface tbrs_in_if;
  logic                valid;
  logic                ready;
  tbrs_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tbrs_out_if;
  logic                valid;
  logic                ready;
  tbrs_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tbrs_cfg_regs.sv -----
// Configuration register file of the shaper: seven write-only registers.
// Depends on tbrs_pkg for the indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module tbrs_cfg_regs (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [tbrs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire  [tbrs_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output tbrs_pkg::cfg_t                      cfg_o
);

  tbrs_pkg::cfg_t cfg_q;

  // Decode the index; writes beyond the last register are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_step         <= tbrs_pkg::RST_ACCEL_STEP;
      cfg_q.decel_step         <= tbrs_pkg::RST_DECEL_STEP;
      cfg_q.emergency_distance <= tbrs_pkg::RST_EMERGENCY_DISTANCE;
      cfg_q.boost_min_distance <= tbrs_pkg::RST_BOOST_MIN_DISTANCE;
      cfg_q.boost_enable       <= tbrs_pkg::RST_BOOST_ENABLE;
      cfg_q.boost_duty         <= tbrs_pkg::RST_BOOST_DUTY;
      cfg_q.boost_duration_ms  <= tbrs_pkg::RST_BOOST_DURATION_MS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tbrs_pkg::CFG_ACCEL_STEP: begin
          cfg_q.accel_step <= cfg_wdata_i[tbrs_pkg::STEP_W-1:0];
        end
        tbrs_pkg::CFG_DECEL_STEP: begin
          cfg_q.decel_step <= cfg_wdata_i[tbrs_pkg::STEP_W-1:0];
        end
        tbrs_pkg::CFG_EMERGENCY_DISTANCE: begin
          cfg_q.emergency_distance <= cfg_wdata_i[tbrs_pkg::DIST_W-1:0];
        end
        tbrs_pkg::CFG_BOOST_MIN_DISTANCE: begin
          cfg_q.boost_min_distance <= cfg_wdata_i[tbrs_pkg::DIST_W-1:0];
        end
        tbrs_pkg::CFG_BOOST_ENABLE: begin
          cfg_q.boost_enable <= cfg_wdata_i[0];
        end
        tbrs_pkg::CFG_BOOST_DUTY: begin
          cfg_q.boost_duty <= cfg_wdata_i[tbrs_pkg::STEP_W-1:0];
        end
        tbrs_pkg::CFG_BOOST_DURATION_MS: begin
          cfg_q.boost_duration_ms <= cfg_wdata_i[tbrs_pkg::DUR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- hw/rtl/tbrs_core.sv -----
// Decision and ramp logic of the shaper with its drive and boost state.
// One control cycle is resolved combinationally; state updates on update_i.
// Depends on tbrs_pkg for cfg_t, in_item_t and out_item_t.
`timescale 1ns / 1ps
`default_nettype none

module tbrs_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  tbrs_pkg::cfg_t       cfg_i,
  input  tbrs_pkg::in_item_t   item_i,
  input  wire                  update_i,
  output tbrs_pkg::out_item_t  result_o
);

  localparam int DW = tbrs_pkg::DUTY_W;
  localparam int TW = tbrs_pkg::TIME_W;

  // Drive and boost state. The boost direction and start time only matter
  // while the boost is on, so they carry no reset.
  logic signed [DW-1:0] last_duty_q, last_duty_d;
  logic                 boost_on_q, boost_on_d;
  logic                 boost_neg_q, boost_neg_d;
  logic [TW-1:0]        boost_start_q, boost_start_d;

  logic signed [DW-1:0] tgt;
  logic                 t_zero, t_pos, t_neg;
  logic                 c_zero, c_pos, c_neg;
  logic                 emergency, reversal, stop, safe, start;
  logic                 bon, bneg, still_boosting;
  logic [TW-1:0]        bstart, elapsed;
  logic signed [DW-1:0] boost_val;

  logic [DW-1:0]        mag_cur, mag_goal;
  logic [DW:0]          abs_cur, abs_goal;
  logic [tbrs_pkg::STEP_W-1:0] step;
  logic signed [DW:0]   cur_x, goal_x, step_x, n_up, n_dn;
  logic signed [DW-1:0] ramp_duty;
  logic signed [DW-1:0] duty;

  // Direction and guard conditions.
  always_comb begin
    tgt       = item_i.target_traction;
    t_zero    = (tgt == '0);
    t_neg     = tgt[DW-1];
    t_pos     = !t_zero && !t_neg;
    c_zero    = (last_duty_q == '0);
    c_neg     = last_duty_q[DW-1];
    c_pos     = !c_zero && !c_neg;
    emergency = item_i.front_valid &&
                (item_i.front_distance <= cfg_i.emergency_distance);
    reversal  = (c_pos && t_neg) || (c_neg && t_pos);
    stop      = t_zero || (emergency && t_pos) || reversal;
    safe      = !item_i.front_valid ||
                (item_i.front_distance >= cfg_i.boost_min_distance) || t_neg;
    start     = cfg_i.boost_enable && c_zero && safe;
  end

  // Boost tracking: a fresh start takes this cycle's direction and time.
  always_comb begin
    bon       = start || boost_on_q;
    bneg      = start ? t_neg : boost_neg_q;
    bstart    = start ? item_i.now_ms : boost_start_q;
    elapsed   = item_i.now_ms - bstart;
    still_boosting = elapsed < {{(TW - tbrs_pkg::DUR_W){1'b0}},
                                cfg_i.boost_duration_ms};
    boost_val = bneg ? -$signed({1'b0, cfg_i.boost_duty})
                     :  $signed({1'b0, cfg_i.boost_duty});
  end

  // Ramp toward the target, accel step when the magnitude grows and decel
  // step when it shrinks, clamped so it never passes the target.
  always_comb begin
    cur_x    = {last_duty_q[DW-1], last_duty_q};
    goal_x   = {tgt[DW-1], tgt};
    abs_cur  = cur_x[DW] ? -cur_x : cur_x;
    abs_goal = goal_x[DW] ? -goal_x : goal_x;
    mag_cur  = abs_cur[DW-1:0];
    mag_goal = abs_goal[DW-1:0];
    step     = (mag_goal > mag_cur) ? cfg_i.accel_step : cfg_i.decel_step;
    step_x   = $signed({1'b0, step});
    n_up     = cur_x + step_x;
    n_dn     = cur_x - step_x;
    if (cur_x == goal_x) begin
      ramp_duty = last_duty_q;
    end else if (cur_x < goal_x) begin
      ramp_duty = (n_up < goal_x) ? n_up[DW-1:0] : tgt;
    end else begin
      ramp_duty = (n_dn > goal_x) ? n_dn[DW-1:0] : tgt;
    end
  end

  // Select the applied duty and the next boost state.
  always_comb begin
    duty          = '0;
    boost_on_d    = 1'b0;
    boost_neg_d   = boost_neg_q;
    boost_start_d = boost_start_q;
    if (stop) begin
      duty = '0;
    end else if (bon) begin
      if (t_neg != bneg) begin
        duty = '0;
      end else if (still_boosting) begin
        duty          = boost_val;
        boost_on_d    = 1'b1;
        boost_neg_d   = bneg;
        boost_start_d = bstart;
      end else begin
        duty = tgt;
      end
    end else begin
      duty = ramp_duty;
    end
    last_duty_d = duty;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_duty_q <= '0;
      boost_on_q  <= 1'b0;
    end else if (update_i) begin
      last_duty_q <= last_duty_d;
      boost_on_q  <= boost_on_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (update_i) begin
      boost_neg_q   <= boost_neg_d;
      boost_start_q <= boost_start_d;
    end
  end

  assign result_o.applied_traction = duty;
  assign result_o.boosting         = boost_on_d;

endmodule

`default_nettype wire

// ----- hw/rtl/traction_boost_and_ramp_shaper.sv -----
// Top level of the traction boost and ramp shaper: input register, core
// logic, result register and configuration registers.
// Depends on tbrs_pkg, tbrs_if, tbrs_cfg_regs and tbrs_core.
//
//   Port         Direction  Handshake         Contents
//   in_i         sink       valid / ready     target, front reading, time
//   out_o        source     valid / ready     applied duty, boost flag
//   cfg_*        in         write enable      register index, write data
//
// An accepted transaction is held in the input register, where the core
// resolves it against the drive state; the result is then registered in the
// result register. One transaction can be taken every clock while out_o
// takes results. A stalled result register holds the input register, and
// input ready drops only when both are full and out_o is not taken. Reset
// clears the drive state and the valid flags and returns the configuration
// registers to their reset values.
`timescale 1ns / 1ps
`default_nettype none

module traction_boost_and_ramp_shaper (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [tbrs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire  [tbrs_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  tbrs_in_if.sink                          in_i,
  tbrs_out_if.source                       out_o
);

  tbrs_pkg::cfg_t      cfg;
  tbrs_pkg::in_item_t  s1_item_q;
  logic                s1_valid_q;
  tbrs_pkg::out_item_t result;
  tbrs_pkg::out_item_t out_item_q;
  logic                out_valid_q;
  logic                advance;
  logic                in_ready;

  tbrs_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The input register moves on when the result register is free or drained.
  assign advance  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !s1_valid_q || advance;
  assign in_i.ready = in_ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s1_item_q <= in_i.data;
    end
  end

  tbrs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_i   (s1_item_q),
    .update_i (advance),
    .result_o (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

endmodule

`default_nettype wire
